// File: sv/pcpa_pkg.sv
// shared types and constants of the per-cpu page allocator
package pcpa_pkg;

	localparam int ADDR_W  = 40;
	localparam int CPU_W   = 3;
	localparam int COUNT_W = 32;

	localparam logic [ADDR_W-1:0] LOW_RESET  = 40'h00_8000_0000;
	localparam logic [ADDR_W-1:0] HIGH_RESET = 40'h00_8800_0000;

	typedef enum logic [1:0] {
		STAT_OK  = 2'd0,
		STAT_OOM = 2'd1,
		STAT_BAD = 2'd2
	} status_t;

	typedef enum logic {
		CFG_LOW  = 1'b0,
		CFG_HIGH = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

endpackage

// File: sv/pcpa_link_ram.sv
// link memory: next slot below each slot on its free list
module pcpa_link_ram #(
	parameter int DEPTH = 32768,
	parameter int WIDTH = 15,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/per_cpu_page_allocator_with_steal_top.sv
// top level of the per-cpu page allocator with single-page steal
//
// Command channel: an item (kind, cpu, addr) is taken at a clock edge with start high and
// busy low. kind 0 allocates a page for cpu, kind 1 frees addr onto the list of cpu.
// Every item gives exactly one result (status, page_addr, stolen, source_cpu), shown for
// one cycle with done high; the receiver cannot hold it off, and busy drops in that same
// cycle so the next item may be taken at once.
// States from the accepting edge to done: free DEC; allocate from own list DEC, LINK; allocate by
// steal DEC, SCAN, POP, LINK; out of memory on an empty cpu DEC, SCAN. The steal cost is set
// by the scan of the list memory, one list count read per cycle; the other paths by the
// registered reads of the list memory and of the link memory.
// The config channel (cfg_valid, cfg_ready, cfg_index, cfg_wdata) writes low_addr (0) or
// high_addr (1); cfg_ready is always high; the user must keep writes to idle periods only,
// as the block has no check. Reset empties every list at once through per-list valid bits;
// the link memory is not cleared, since it is only read along links that frees have written.
module per_cpu_page_allocator_with_steal_top #(
	parameter int CPU_COUNT  = 8,
	parameter int MAX_PAGES  = 32768,
	parameter int PAGE_SHIFT = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        kind,
	input  logic [pcpa_pkg::CPU_W-1:0]  cpu,
	input  logic [pcpa_pkg::ADDR_W-1:0] addr,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [pcpa_pkg::ADDR_W-1:0] page_addr,
	output logic                        stolen,
	output logic [pcpa_pkg::CPU_W-1:0]  source_cpu,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [pcpa_pkg::ADDR_W-1:0] cfg_wdata
);

	localparam int ADDR_W  = pcpa_pkg::ADDR_W;
	localparam int COUNT_W = pcpa_pkg::COUNT_W;
	localparam int LW      = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
	localparam int SW      = $clog2(MAX_PAGES);
	localparam int PN      = ADDR_W - PAGE_SHIFT;
	localparam int BW      = PN + 1;
	localparam logic [LW-1:0] LAST = LW'(CPU_COUNT - 1);
	localparam logic [ADDR_W:0] PG_M1 = (41'(1) << PAGE_SHIFT) - 41'(1);
	localparam logic [BW-1:0] BASE_RESET =
		BW'((41'(pcpa_pkg::LOW_RESET) + PG_M1) >> PAGE_SHIFT);

	typedef struct packed {
		logic [COUNT_W-1:0] cnt;
		logic [SW-1:0]      head;
	} ent_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEC,
		ST_SCAN,
		ST_POP,
		ST_LINK
	} state_t;

	state_t state_q;

	logic [ADDR_W-1:0] low_q;
	logic [ADDR_W-1:0] high_q;
	logic [BW-1:0]     base_q;

	logic          kind_q;
	logic          cpu_ok_q;
	logic          bad_q;
	logic [LW-1:0] cidx_q;
	logic [PN-1:0] pn_q;

	logic [LW-1:0]      scan_q;
	logic [LW-1:0]      best_q;
	logic [COUNT_W-1:0] bestcnt_q;
	logic [LW-1:0]      src_q;
	logic               steal_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [SW-1:0]      slot_q;

	logic                 done_q;
	pcpa_pkg::status_t    status_q;
	logic [ADDR_W-1:0]    page_q;
	logic                 stolen_q;
	logic [pcpa_pkg::CPU_W-1:0] srcout_q;

	// list memory with valid bits
	ent_t             lmem [CPU_COUNT];
	logic [CPU_COUNT-1:0] valid_q;
	ent_t             lm_rd_q;
	logic [LW-1:0]    lm_ridx_q;
	logic             lm_we;
	logic [LW-1:0]    lm_waddr;
	ent_t             lm_wdata;
	logic             lm_re;
	logic [LW-1:0]    lm_raddr;
	ent_t             ent;

	logic          lk_we;
	logic [SW-1:0] lk_waddr;
	logic [SW-1:0] lk_wdata;
	logic          lk_re;
	logic [SW-1:0] lk_raddr;
	logic [SW-1:0] lk_rd;

	logic          accept;
	logic          in_cpu_ok;
	logic [LW-1:0] in_idx;
	logic          in_bad;

	logic [BW-1:0]      diff;
	logic               slot_ok;
	logic [SW-1:0]      slot;
	logic [COUNT_W-1:0] cnt_inc;
	logic               gt;
	logic [LW-1:0]      fin_best;
	logic [COUNT_W-1:0] fin_cnt;
	logic [BW:0]        pg_sum;
	logic [ADDR_W+1:0]  pa_wide;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	assign in_cpu_ok = 32'(cpu) < CPU_COUNT;
	assign in_idx    = in_cpu_ok ? LW'(cpu) : '0;
	assign in_bad    = !in_cpu_ok || (addr[PAGE_SHIFT-1:0] != '0) || (addr < low_q) ||
		(addr >= high_q);

	assign ent     = valid_q[lm_ridx_q] ? lm_rd_q : '0;
	assign diff    = BW'(pn_q) - base_q;
	assign slot_ok = 64'(diff) < 64'(MAX_PAGES);
	assign slot    = diff[SW-1:0];
	assign cnt_inc = (ent.cnt != '1) ? ent.cnt + 1'b1 : ent.cnt;

	assign gt       = ent.cnt > bestcnt_q;
	assign fin_best = gt ? scan_q : best_q;
	assign fin_cnt  = gt ? ent.cnt : bestcnt_q;

	assign pg_sum  = (BW + 1)'(base_q) + (BW + 1)'(slot_q);
	assign pa_wide = {pg_sum, {PAGE_SHIFT{1'b0}}};

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= pcpa_pkg::LOW_RESET;
			high_q <= pcpa_pkg::HIGH_RESET;
			base_q <= BASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pcpa_pkg::CFG_LOW: begin
					low_q  <= cfg_wdata;
					base_q <= BW'((41'(cfg_wdata) + PG_M1) >> PAGE_SHIFT);
				end
				pcpa_pkg::CFG_HIGH: begin
					high_q <= cfg_wdata;
				end
			endcase
		end
	end

	// memory access decode
	always_comb begin
		lm_we    = 1'b0;
		lm_waddr = cidx_q;
		lm_wdata = '0;
		lm_re    = 1'b0;
		lm_raddr = '0;
		lk_we    = 1'b0;
		lk_waddr = slot;
		lk_wdata = ent.head;
		lk_re    = 1'b0;
		lk_raddr = ent.head;
		unique case (state_q)
			ST_IDLE: begin
				lm_re    = accept;
				lm_raddr = in_idx;
			end
			ST_DEC: begin
				if (kind_q == pcpa_pkg::KIND_FREE) begin
					if (!bad_q && slot_ok) begin
						lm_we    = 1'b1;
						lm_wdata = '{cnt: cnt_inc, head: slot};
						lk_we    = 1'b1;
					end
				end else if (cpu_ok_q) begin
					if (ent.cnt != '0) begin
						lk_re = 1'b1;
					end else begin
						lm_re = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (scan_q != LAST) begin
					lm_re    = 1'b1;
					lm_raddr = scan_q + LW'(1);
				end else if (fin_cnt != '0) begin
					lm_re    = 1'b1;
					lm_raddr = fin_best;
				end
			end
			ST_POP: begin
				lk_re = 1'b1;
			end
			ST_LINK: begin
				lm_we    = 1'b1;
				lm_waddr = src_q;
				lm_wdata = '{cnt: cnt_q - 1'b1, head: lk_rd};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (lm_we) begin
			lmem[lm_waddr] <= lm_wdata;
		end
		if (lm_re) begin
			lm_rd_q <= lmem[lm_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			lm_ridx_q <= '0;
		end else begin
			if (lm_we) begin
				valid_q[lm_waddr] <= 1'b1;
			end
			if (lm_re) begin
				lm_ridx_q <= lm_raddr;
			end
		end
	end

	pcpa_link_ram #(
		.DEPTH(MAX_PAGES),
		.WIDTH(SW)
	) u_link (
		.clk  (clk),
		.we   (lk_we),
		.waddr(lk_waddr),
		.wdata(lk_wdata),
		.re   (lk_re),
		.raddr(lk_raddr),
		.rdata(lk_rd)
	);

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			status_q  <= pcpa_pkg::STAT_OK;
			page_q    <= '0;
			stolen_q  <= 1'b0;
			srcout_q  <= '0;
			kind_q    <= 1'b0;
			cpu_ok_q  <= 1'b0;
			bad_q     <= 1'b0;
			cidx_q    <= '0;
			pn_q      <= '0;
			scan_q    <= '0;
			best_q    <= '0;
			bestcnt_q <= '0;
			src_q     <= '0;
			steal_q   <= 1'b0;
			cnt_q     <= '0;
			slot_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						kind_q   <= kind;
						cpu_ok_q <= in_cpu_ok;
						bad_q    <= in_bad;
						cidx_q   <= in_idx;
						pn_q     <= addr[ADDR_W-1:PAGE_SHIFT];
						state_q  <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (kind_q == pcpa_pkg::KIND_FREE) begin
						done_q   <= 1'b1;
						status_q <= (!bad_q && slot_ok) ? pcpa_pkg::STAT_OK
							: pcpa_pkg::STAT_BAD;
						page_q   <= '0;
						stolen_q <= 1'b0;
						srcout_q <= '0;
						state_q  <= ST_IDLE;
					end else if (!cpu_ok_q) begin
						done_q   <= 1'b1;
						status_q <= pcpa_pkg::STAT_OOM;
						page_q   <= '0;
						stolen_q <= 1'b0;
						srcout_q <= '0;
						state_q  <= ST_IDLE;
					end else if (ent.cnt != '0) begin
						src_q   <= cidx_q;
						steal_q <= 1'b0;
						cnt_q   <= ent.cnt;
						slot_q  <= ent.head;
						state_q <= ST_LINK;
					end else begin
						scan_q    <= '0;
						best_q    <= '0;
						bestcnt_q <= '0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					best_q    <= fin_best;
					bestcnt_q <= fin_cnt;
					scan_q    <= scan_q + LW'(1);
					if (scan_q == LAST) begin
						if (fin_cnt == '0) begin
							done_q   <= 1'b1;
							status_q <= pcpa_pkg::STAT_OOM;
							page_q   <= '0;
							stolen_q <= 1'b0;
							srcout_q <= '0;
							state_q  <= ST_IDLE;
						end else begin
							src_q   <= fin_best;
							steal_q <= 1'b1;
							state_q <= ST_POP;
						end
					end
				end
				ST_POP: begin
					cnt_q   <= ent.cnt;
					slot_q  <= ent.head;
					state_q <= ST_LINK;
				end
				ST_LINK: begin
					done_q   <= 1'b1;
					status_q <= pcpa_pkg::STAT_OK;
					page_q   <= pa_wide[ADDR_W-1:0];
					stolen_q <= steal_q;
					srcout_q <= pcpa_pkg::CPU_W'(src_q);
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign page_addr  = page_q;
	assign stolen     = stolen_q;
	assign source_cpu = srcout_q;

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an item in progress");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not start work");

	a_oom_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == pcpa_pkg::STAT_OOM) |-> (page_addr == '0) && !stolen &&
		(source_cpu == '0))
		else $error("out of memory result carries a page");

	a_steal_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && stolen |-> (status == pcpa_pkg::STAT_OK))
		else $error("stolen flag on a failed transaction");

	a_link_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LINK) |-> ($past(state_q) == ST_POP) || ($past(state_q) == ST_DEC))
		else $error("link write-back without a link read");

endmodule

// File: verif/page_alloc_checker.sv
`timescale 1ns / 100ps
// checker that predicts allocator results from accepted transactions and compares them
module page_alloc_checker #(
	parameter int CPU_COUNT  = 8,
	parameter int MAX_PAGES  = 32768,
	parameter int PAGE_SHIFT = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic                        kind,
	input  logic [pcpa_pkg::CPU_W-1:0]  cpu,
	input  logic [pcpa_pkg::ADDR_W-1:0] addr,
	input  logic                        done,
	input  logic [1:0]                  status,
	input  logic [pcpa_pkg::ADDR_W-1:0] page_addr,
	input  logic                        stolen,
	input  logic [pcpa_pkg::CPU_W-1:0]  source_cpu,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [pcpa_pkg::ADDR_W-1:0] cfg_wdata,
	output int                          mismatches,
	output int                          outstanding
);

	localparam int ADDR_W  = pcpa_pkg::ADDR_W;
	localparam int CPU_W   = pcpa_pkg::CPU_W;
	localparam int COUNT_W = pcpa_pkg::COUNT_W;
	localparam int SLOT_W  = $clog2(MAX_PAGES);

	typedef struct packed {
		pcpa_pkg::status_t status;
		logic [ADDR_W-1:0] page_addr;
		logic              stolen;
		logic [CPU_W-1:0]  source_cpu;
	} page_result_t;

	logic [ADDR_W-1:0]  low_bound;
	logic [ADDR_W-1:0]  high_bound;
	logic [SLOT_W-1:0]  head_slot [CPU_COUNT];
	logic [COUNT_W-1:0] free_count [CPU_COUNT];
	logic [SLOT_W-1:0]  link_below [MAX_PAGES];
	page_result_t       expected_results [$];
	page_result_t       oldest;
	int                 err_count;

	function automatic logic [63:0] first_page();
		return ({24'b0, low_bound} + (64'd1 << PAGE_SHIFT) - 64'd1) >> PAGE_SHIFT;
	endfunction

	function automatic page_result_t predict_page_result(logic k, logic [CPU_W-1:0] c,
			logic [ADDR_W-1:0] a);
		page_result_t      r;
		logic [63:0]       slot;
		logic [63:0]       full_addr;
		logic [SLOT_W-1:0] taken;
		int                src;
		int                best;
		r.status     = pcpa_pkg::STAT_OK;
		r.page_addr  = '0;
		r.stolen     = 1'b0;
		r.source_cpu = '0;
		if (k == pcpa_pkg::KIND_FREE) begin
			if (int'(c) >= CPU_COUNT || a[PAGE_SHIFT-1:0] != '0 || a < low_bound ||
					a >= high_bound) begin
				r.status = pcpa_pkg::STAT_BAD;
				return r;
			end
			slot = ({24'b0, a} >> PAGE_SHIFT) - first_page();
			if (slot >= 64'(MAX_PAGES)) begin
				r.status = pcpa_pkg::STAT_BAD;
				return r;
			end
			link_below[slot[SLOT_W-1:0]] = head_slot[c];
			head_slot[c] = slot[SLOT_W-1:0];
			if (free_count[c] != '1)
				free_count[c] = free_count[c] + 1'b1;
			return r;
		end
		if (int'(c) >= CPU_COUNT) begin
			r.status = pcpa_pkg::STAT_OOM;
			return r;
		end
		src = int'(c);
		if (free_count[c] == '0) begin
			best = 0;
			for (int i = 1; i < CPU_COUNT; i++)
				if (free_count[i] > free_count[best])
					best = i;
			if (free_count[best] == '0) begin
				r.status = pcpa_pkg::STAT_OOM;
				return r;
			end
			src = best;
			r.stolen = 1'b1;
		end
		taken = head_slot[src];
		head_slot[src] = link_below[taken];
		free_count[src] = free_count[src] - 1'b1;
		full_addr = (first_page() + {{(64-SLOT_W){1'b0}}, taken}) << PAGE_SHIFT;
		r.page_addr  = full_addr[ADDR_W-1:0];
		r.source_cpu = src[CPU_W-1:0];
		return r;
	endfunction

	task automatic check_field(string field, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_bound  = pcpa_pkg::LOW_RESET;
			high_bound = pcpa_pkg::HIGH_RESET;
			for (int i = 0; i < CPU_COUNT; i++) begin
				head_slot[i]  = '0;
				free_count[i] = '0;
			end
			for (int i = 0; i < MAX_PAGES; i++)
				link_below[i] = '0;
			expected_results.delete();
			err_count = 0;
			outstanding <= 0;
			mismatches  <= 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with no transaction pending, status %h page_addr %h",
						$time, status, page_addr);
					err_count++;
				end else begin
					oldest = expected_results.pop_front();
					check_field("status", ADDR_W'(oldest.status), ADDR_W'(status));
					check_field("page_addr", oldest.page_addr, page_addr);
					check_field("stolen", ADDR_W'(oldest.stolen), ADDR_W'(stolen));
					check_field("source_cpu", ADDR_W'(oldest.source_cpu), ADDR_W'(source_cpu));
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == pcpa_pkg::CFG_LOW)
					low_bound = cfg_wdata;
				else
					high_bound = cfg_wdata;
			end
			if (start && !busy)
				expected_results.push_back(predict_page_result(kind, cpu, addr));
			outstanding <= expected_results.size();
			mismatches  <= err_count;
		end
	end

endmodule

// File: verif/per_cpu_page_allocator_with_steal_top_test.sv
`timescale 1ns / 100ps
// stimulus and verdict for the per-cpu page allocator with single-page steal
module per_cpu_page_allocator_with_steal_top_test;

	localparam int ADDR_W        = pcpa_pkg::ADDR_W;
	localparam int CPU_W         = pcpa_pkg::CPU_W;
	localparam int CPU_COUNT     = 8;
	localparam int MAX_PAGES     = 32768;
	localparam int PAGE_SHIFT    = 12;
	localparam int SETTLE_CYCLES = 2 * (CPU_COUNT + 5);
	localparam int PHASE_ITEMS   = 147;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	logic              kind      = 1'b0;
	logic [CPU_W-1:0]  cpu       = '0;
	logic [ADDR_W-1:0] addr      = '0;
	logic              cfg_valid = 1'b0;
	logic              cfg_index = 1'b0;
	logic [ADDR_W-1:0] cfg_wdata = '0;
	logic              busy;
	logic              done;
	logic [1:0]        status;
	logic [ADDR_W-1:0] page_addr;
	logic              stolen;
	logic [CPU_W-1:0]  source_cpu;
	logic              cfg_ready;
	int                mismatches;
	int                outstanding;

	logic [ADDR_W-1:0] cur_low  = pcpa_pkg::LOW_RESET;
	logic [ADDR_W-1:0] cur_high = pcpa_pkg::HIGH_RESET;
	int                alloc_pct = 40;
	logic              burst     = 1'b0;

	per_cpu_page_allocator_with_steal_top #(
		.CPU_COUNT(CPU_COUNT),
		.MAX_PAGES(MAX_PAGES),
		.PAGE_SHIFT(PAGE_SHIFT)
	) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind), .cpu(cpu),
		.addr(addr), .done(done), .status(status), .page_addr(page_addr), .stolen(stolen),
		.source_cpu(source_cpu), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	page_alloc_checker #(
		.CPU_COUNT(CPU_COUNT),
		.MAX_PAGES(MAX_PAGES),
		.PAGE_SHIFT(PAGE_SHIFT)
	) u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind), .cpu(cpu),
		.addr(addr), .done(done), .status(status), .page_addr(page_addr), .stolen(stolen),
		.source_cpu(source_cpu), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_wdata(cfg_wdata), .mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [ADDR_W-1:0] rand40();
		logic [7:0] upper;
		upper = 8'($urandom_range(0, 255));
		return {upper, 32'($urandom)};
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst && r < 95)
			return 0;
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	// page address inside the current window (random when the window is empty), mostly from a small pool so pages repeat
	function automatic logic [ADDR_W-1:0] window_page();
		logic [63:0] base;
		logic [63:0] top;
		logic [63:0] span;
		logic [63:0] slot;
		logic [63:0] full_addr;
		base = ({24'b0, cur_low} + (64'd1 << PAGE_SHIFT) - 64'd1) >> PAGE_SHIFT;
		top  = ({24'b0, cur_high} - 64'd1) >> PAGE_SHIFT;
		if (cur_high == '0 || top < base)
			return rand40();
		span = top - base + 64'd1;
		if ($urandom_range(0, 19) == 0)
			slot = 64'($urandom_range(0, (span > 64'(MAX_PAGES + 16)) ?
				MAX_PAGES + 15 : int'(span) - 1));
		else
			slot = 64'($urandom_range(0, (span > 64'd48) ? 47 : int'(span) - 1));
		full_addr = (base + slot) << PAGE_SHIFT;
		return full_addr[ADDR_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] broken_page();
		unique case ($urandom_range(0, 3))
			0: return window_page() + ADDR_W'($urandom_range(1, (1 << PAGE_SHIFT) - 1));
			1: return cur_low - ADDR_W'($urandom_range(1, 3) << PAGE_SHIFT);
			2: return cur_high;
			default: return rand40();
		endcase
	endfunction

	task automatic send_item(logic k, logic [CPU_W-1:0] c, logic [ADDR_W-1:0] a);
		int gap;
		start <= 1'b1;
		kind  <= k;
		cpu   <= c;
		addr  <= a;
		do @(posedge clk); while (busy);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= pcpa_pkg::CFG_LOW;
		cfg_wdata <= lo;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= pcpa_pkg::CFG_HIGH;
		cfg_wdata <= hi;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_low  = lo;
		cur_high = hi;
	endtask

	// allocs lean on cpus 0..3 and frees on 4..7 so own lists run dry and steals happen
	task automatic random_item();
		int               r;
		logic [CPU_W-1:0] c;
		r = $urandom_range(0, 99);
		if (r < alloc_pct) begin
			c = ($urandom_range(0, 9) < 7) ? CPU_W'($urandom_range(0, 3)) : CPU_W'($urandom);
			send_item(pcpa_pkg::KIND_ALLOC, c, rand40());
		end else if (r < 88) begin
			c = ($urandom_range(0, 9) < 7) ? CPU_W'($urandom_range(4, 7)) : CPU_W'($urandom);
			send_item(pcpa_pkg::KIND_FREE, c, window_page());
		end else begin
			send_item(pcpa_pkg::KIND_FREE, CPU_W'($urandom), broken_page());
		end
		if ($urandom_range(0, 99) < 2)
			drain();
	endtask

	initial begin
		logic [ADDR_W-1:0] lo;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(pcpa_pkg::KIND_ALLOC, 3'd0, '0);
		send_item(pcpa_pkg::KIND_FREE, 3'd0, 40'h00_8000_0000);
		send_item(pcpa_pkg::KIND_FREE, 3'd7, 40'h00_87FF_F000);
		send_item(pcpa_pkg::KIND_FREE, 3'd1, 40'h00_8800_0000);
		send_item(pcpa_pkg::KIND_FREE, 3'd2, 40'h00_7FFF_F000);
		send_item(pcpa_pkg::KIND_FREE, 3'd2, 40'h00_8000_0001);
		send_item(pcpa_pkg::KIND_FREE, 3'd0, '0);
		send_item(pcpa_pkg::KIND_FREE, 3'd7, '1);
		send_item(pcpa_pkg::KIND_FREE, 3'd3, 40'h00_8000_5000);
		send_item(pcpa_pkg::KIND_FREE, 3'd3, 40'h00_8000_5000);
		send_item(pcpa_pkg::KIND_ALLOC, 3'd0, '1);
		send_item(pcpa_pkg::KIND_ALLOC, 3'd0, '0);
		send_item(pcpa_pkg::KIND_ALLOC, 3'd5, '0);
		send_item(pcpa_pkg::KIND_ALLOC, 3'd5, '0);
		send_item(pcpa_pkg::KIND_ALLOC, 3'd6, '0);
		send_item(pcpa_pkg::KIND_FREE, 3'd6, 40'h00_8000_1000);
		send_item(pcpa_pkg::KIND_FREE, 3'd6, 40'h00_8000_2000);
		send_item(pcpa_pkg::KIND_ALLOC, 3'd6, '0);
		send_item(pcpa_pkg::KIND_ALLOC, 3'd6, '0);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			unique case (phase)
				1: configure('0, '1);
				2: configure(40'h00_1234_5678, 40'h00_1234_5678 + (40'd40 << PAGE_SHIFT));
				3: configure(40'hFF_FFF0_0000, '1);
				4: configure('0, '0);
				5: begin
					lo = rand40();
					configure(lo, lo + (ADDR_W'($urandom_range(1, 3000)) << PAGE_SHIFT));
				end
				default: ;
			endcase
			alloc_pct = (phase % 3 == 0) ? 30 : ((phase % 3 == 1) ? 45 : 60);
			burst = phase[0];
			repeat (PHASE_ITEMS) random_item();
		end
		drain();

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
